### rtl/abck_pkg.sv
`default_nettype none

package abck_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_BLEND_MODE       = 2'd0;
	localparam logic [1:0] CFG_CONSTANT_ALPHA   = 2'd1;
	localparam logic [1:0] CFG_USE_SOURCE_ALPHA = 2'd2;
	localparam logic [1:0] CFG_COLOR_KEY        = 2'd3;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 24;

	// Beat widths: payload rounded up to whole bytes
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 40;

	localparam logic [7:0] ALPHA_MAX = 8'd255;

	// Divide by 255 with rounding, for values up to 2 * 255 * 255.
	// Estimate the quotient by shifts, then correct it by one remainder check.
	function automatic logic [8:0] div255r(input logic [16:0] v);
		logic [16:0] x;
		logic [16:0] acc;
		logic [8:0]  q;
		logic [16:0] r;
		x   = v + 17'd127;
		acc = x + (x >> 8);
		q   = acc[16:8];
		r   = x - (17'(q) * 17'd255);
		if (r >= 17'd255) begin
			q = q + 9'd1;
		end
		return q;
	endfunction

	// Clamp a rounded channel to one byte
	function automatic logic [7:0] sat8(input logic [8:0] v);
		logic [7:0] res;
		res = v[8] ? 8'hff : v[7:0];
		return res;
	endfunction

endpackage

`default_nettype wire

### rtl/alpha_blend_color_key_compositor_top.sv
`default_nettype none

// Channel | Direction | Handshake             | Payload
// s_axis  | in        | tvalid / tready       | tdata: src_pixel, src_ok, dst_pixel, dst_ok
// m_axis  | out       | tvalid / tready       | tdata: write_enable, out_pixel
// cfg     | in        | we (no wait)          | addr: register index, wdata: value
//
// One pixel per clock unless the output is held; each result leaves once its beat has passed every stage.
// The four stages (key compare and alpha product, opacity divide, channel
// products, channel divide and saturate) all advance together, so the depth
// of the pipeline sets the latency and the single shared enable sets the rate.
// A held output stalls every stage; no beat is lost or repeated.
// Reset clears the valid bits and loads the register reset values.
module alpha_blend_color_key_compositor_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration
	input  wire logic                             cfg_we,
	input  wire logic [abck_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [abck_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// input stream
	input  wire logic                             s_axis_tvalid,
	output      logic                             s_axis_tready,
	// tdata: src_pixel[31:0], src_ok[32], dst_pixel[64:33], dst_ok[65], zeros[71:66]
	input  wire logic [abck_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// output stream
	output      logic                             m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// tdata: write_enable[0], out_pixel[32:1], zeros[39:33]
	output      logic [abck_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import abck_pkg::*;

	logic        blend_mode_q;
	logic [7:0]  constant_alpha_q;
	logic        use_source_alpha_q;
	logic [23:0] color_key_q;

	logic        adv;

	logic [31:0] in_src;
	logic        in_src_ok;
	logic [31:0] in_dst;
	logic        in_dst_ok;
	logic        key_match;

	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic        we_s1, we_s2, we_s3, we_s4;
	logic [31:0] src_s1, src_s2, src_s3;
	logic [31:0] dst_s1, dst_s2;
	logic [15:0] sa_prod_s1;
	logic [7:0]  op_s2, op_s3;
	logic [7:0]  inv_s2;
	logic [16:0] ch_sum_s3 [3];
	logic [15:0] a_prod_s3;
	logic [31:0] pix_s4;

	logic [8:0]  op_div;
	logic [7:0]  op_next;
	logic [31:0] pix_next;
	logic [8:0]  a_div;
	logic [8:0]  ch_div [3];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q       <= 1'b0;
			constant_alpha_q   <= ALPHA_MAX;
			use_source_alpha_q <= 1'b0;
			color_key_q        <= 24'd0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_BLEND_MODE:       blend_mode_q       <= cfg_wdata[0];
				CFG_CONSTANT_ALPHA:   constant_alpha_q   <= cfg_wdata[7:0];
				CFG_USE_SOURCE_ALPHA: use_source_alpha_q <= cfg_wdata[0];
				CFG_COLOR_KEY:        color_key_q        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Advance every stage together unless the output beat is held
	assign adv           = !vld_s4 || m_axis_tready;
	assign s_axis_tready = adv;

	// Unpack the input beat
	assign in_src    = s_axis_tdata[31:0];
	assign in_src_ok = s_axis_tdata[32];
	assign in_dst    = s_axis_tdata[64:33];
	assign in_dst_ok = s_axis_tdata[65];

	// Compare colour bytes in reference order: red low, blue high
	assign key_match = ({in_src[7:0], in_src[15:8], in_src[23:16]} == color_key_q);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Stage 1: write decision and source alpha product
	always_ff @(posedge clk) begin
		if (adv) begin
			src_s1     <= in_src;
			dst_s1     <= in_dst;
			we_s1      <= in_src_ok && (blend_mode_q ? !key_match : in_dst_ok);
			sa_prod_s1 <= 16'(in_src[31:24]) * 16'(constant_alpha_q);
		end
	end

	// Stage 2: opacity and its complement
	assign op_div  = div255r(17'(sa_prod_s1));
	assign op_next = use_source_alpha_q ? op_div[7:0] : constant_alpha_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s2 <= src_s1;
			dst_s2 <= dst_s1;
			we_s2  <= we_s1;
			op_s2  <= op_next;
			inv_s2 <= ALPHA_MAX - op_next;
		end
	end

	// Stage 3: channel and alpha products
	always_ff @(posedge clk) begin
		if (adv) begin
			src_s3    <= src_s2;
			we_s3     <= we_s2;
			op_s3     <= op_s2;
			a_prod_s3 <= 16'(dst_s2[31:24]) * 16'(inv_s2);
			for (int c = 0; c < 3; c++) begin
				ch_sum_s3[c] <= 17'(16'(src_s2[8*c +: 8]) * 16'(constant_alpha_q))
					+ 17'(16'(dst_s2[8*c +: 8]) * 16'(inv_s2));
			end
		end
	end

	// Stage 4: divide, saturate and pick the result pixel
	assign a_div = div255r(17'(a_prod_s3));

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ch_div[c] = div255r(ch_sum_s3[c]);
		end
		if (!we_s3) begin
			pix_next = 32'd0;
		end else if (blend_mode_q) begin
			pix_next = src_s3;
		end else begin
			pix_next = {op_s3 + a_div[7:0], sat8(ch_div[2]), sat8(ch_div[1]),
				sat8(ch_div[0])};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			we_s4  <= we_s3;
			pix_s4 <= pix_next;
		end
	end

	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = {7'd0, pix_s4, we_s4};

endmodule

`default_nettype wire

### rtl/abck_chk.sv
`default_nettype none

module abck_chk (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [abck_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import abck_pkg::*;

	// Hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// Drop the pixel to zero whenever nothing is written
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
		else $error("pixel not zero on a beat without write");

	// Stall the input whenever the output beat is held
	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output held");

	// A beat taken into an empty, free-running pipe comes out once it has passed every stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid
		##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
		|=> m_axis_tvalid)
		else $error("result missing after four cycles");

	// Keep the padding bits of the output beat clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:33] == '0)
		else $error("output padding not zero");

endmodule

bind alpha_blend_color_key_compositor_top abck_chk u_abck_chk (.*);

`default_nettype wire

### verif/tb_alpha_blend_color_key_compositor_top.sv
`timescale 1ns / 100ps

typedef enum logic {
	MODE_BLEND = 1'b0,
	MODE_KEY   = 1'b1
} blend_mode_t;

typedef struct packed {
	logic        we;
	logic [31:0] pixel;
} blend_result_t;

// Mirror of the register file plus the pixels still owed by the block
class blend_scoreboard;
	blend_mode_t   mode;
	logic [7:0]    const_alpha;
	logic          use_src_alpha;
	logic [23:0]   color_key;
	blend_result_t due_pixels[$];
	int            taken;
	int            checked;
	int            suppressed;
	int            errors;

	function new();
		mode          = MODE_BLEND;
		const_alpha   = abck_pkg::ALPHA_MAX;
		use_src_alpha = 1'b0;
		color_key     = '0;
		taken         = 0;
		checked       = 0;
		suppressed    = 0;
		errors        = 0;
	endfunction

	function int unsigned round_div255(int unsigned v);
		return (v + 127) / 255;
	endfunction

	// Work out the composited pixel for one accepted beat and queue it
	function void note_pixel(logic [31:0] src, logic src_ok, logic [31:0] dst, logic dst_ok);
		blend_result_t res;
		int unsigned   opacity;
		int unsigned   remain;
		int unsigned   chan;
		res = '0;
		taken++;
		if (src_ok && mode == MODE_KEY) begin
			// key is held red-low, blue-high
			if ({src[7:0], src[15:8], src[23:16]} != color_key) begin
				res.we    = 1'b1;
				res.pixel = src;
			end
		end else if (src_ok && dst_ok) begin
			if (use_src_alpha) begin
				opacity = round_div255(32'(src[31:24]) * 32'(const_alpha));
			end else begin
				opacity = const_alpha;
			end
			remain = 255 - opacity;
			for (int sh = 0; sh < 24; sh += 8) begin
				chan = round_div255(src[sh +: 8] * const_alpha + dst[sh +: 8] * remain);
				// saturate the colour channel
				if (chan > 255) begin
					chan = 255;
				end
				res.pixel[sh +: 8] = 8'(chan);
			end
			res.pixel[31:24] = 8'(opacity + round_div255(dst[31:24] * remain));
			res.we = 1'b1;
		end
		if (!res.we) begin
			suppressed++;
		end
		due_pixels.push_back(res);
	endfunction

	task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %h, expected %h", what, got, want);
	endtask

	// Compare one output beat with the oldest pixel owed
	task check_pixel(logic we, logic [31:0] pixel);
		blend_result_t want;
		if (due_pixels.size() == 0) begin
			report_mismatch("unexpected output beat", pixel, '0);
		end else begin
			want = due_pixels.pop_front();
			checked++;
			if (we !== want.we) begin
				report_mismatch("write_enable", 32'(we), 32'(want.we));
			end
			if (pixel !== want.pixel) begin
				report_mismatch("out_pixel", pixel, want.pixel);
			end
		end
	endtask

	function int pending();
		return due_pixels.size();
	endfunction
endclass

module tb_alpha_blend_color_key_compositor_top;
	import abck_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_AT     = 600;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASES      = 8;
	localparam int PHASE_BEATS = 140;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// tdata: src_pixel, src_ok, dst_pixel, dst_ok, zero pad
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// tdata: write_enable, out_pixel, zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	blend_scoreboard board;
	bit              steady = 1'b0;
	bit              held   = 1'b0;
	int              stall_cycles = 0;
	int              settings_used = 0;
	int              hold_count;

	alpha_blend_color_key_compositor_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one pixel beat, idling now and then, and hold until taken
	task automatic send_pixel(input logic [31:0] src, input logic src_ok,
			input logic [31:0] dst, input logic dst_ok);
		while (!steady && $urandom_range(99) < 6) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, dst_ok, dst, src_ok, src};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		board.note_pixel(src, src_ok, dst, dst_ok);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// Drain the pipeline, then load all four registers
	task automatic apply_settings(input blend_mode_t mode, input logic [7:0] alpha,
			input logic use_alpha, input logic [23:0] key);
		s_axis_tvalid <= 1'b0;
		while (board.pending() > 0) begin
			@(posedge clk);
		end
		repeat (2) @(posedge clk);
		write_reg(CFG_BLEND_MODE, CFG_DATA_W'(mode));
		write_reg(CFG_CONSTANT_ALPHA, CFG_DATA_W'(alpha));
		write_reg(CFG_USE_SOURCE_ALPHA, CFG_DATA_W'(use_alpha));
		write_reg(CFG_COLOR_KEY, key);
		cfg_we <= 1'b0;
		board.mode          = mode;
		board.const_alpha   = alpha;
		board.use_src_alpha = use_alpha;
		board.color_key     = key;
		settings_used++;
	endtask

	// Bias each byte towards its extremes
	function automatic logic [31:0] random_pixel();
		logic [31:0] p;
		for (int b = 0; b < 4; b++) begin
			case ($urandom_range(7))
				0: begin
					p[b*8 +: 8] = 8'h00;
				end
				1: begin
					p[b*8 +: 8] = 8'hff;
				end
				default: begin
					p[b*8 +: 8] = 8'($urandom);
				end
			endcase
		end
		return p;
	endfunction

	// Check every output beat
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			board.check_pixel(m_axis_tdata[0], m_axis_tdata[32:1]);
		end
	end

	// Abort when nothing moves on either side for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("alpha_blend_color_key_compositor_top verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Receiver: random back-pressure, with one long hold-off to fill the pipeline
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held && board.taken >= HOLD_AT) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
					@(posedge clk);
				end
			end else begin
				m_axis_tready <= steady || ($urandom_range(99) >= 6);
			end
		end
	end

	initial begin
		logic [31:0] src;
		logic [31:0] dst;
		logic        src_ok;
		logic        dst_ok;
		logic [7:0]  alpha;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: full constant alpha, plain blend
		send_pixel(32'hffffffff, 1'b1, 32'hffffffff, 1'b1);
		send_pixel(32'h00000000, 1'b1, 32'h00000000, 1'b1);
		send_pixel(32'h12345678, 1'b0, 32'h9abcdef0, 1'b1);
		send_pixel(32'h12345678, 1'b1, 32'h9abcdef0, 1'b0);
		send_pixel(32'h00000000, 1'b1, 32'hffffffff, 1'b1);

		// Zero constant alpha leaves the destination
		apply_settings(MODE_BLEND, 8'd0, 1'b0, 24'h000000);
		send_pixel(32'hffffffff, 1'b1, 32'h80402010, 1'b1);
		send_pixel(32'h7f7f7f7f, 1'b1, 32'hffffffff, 1'b1);

		// Source alpha scaling; transparent white over white overflows the channels
		apply_settings(MODE_BLEND, 8'd255, 1'b1, 24'h000000);
		send_pixel(32'h00ffffff, 1'b1, 32'hffffffff, 1'b1);
		send_pixel(32'hff123456, 1'b1, 32'h00abcdef, 1'b1);
		send_pixel(32'h80ff00ff, 1'b1, 32'h7f00ff00, 1'b1);
		apply_settings(MODE_BLEND, 8'd128, 1'b1, 24'h000000);
		send_pixel(32'h7fc0c0c0, 1'b1, 32'h40404040, 1'b1);
		send_pixel(32'h01ffffff, 1'b0, 32'h40404040, 1'b1);

		// Colour key: match ignores alpha and the destination flag
		apply_settings(MODE_KEY, 8'd255, 1'b0, 24'h332211);
		send_pixel(32'haa112233, 1'b1, 32'h00000000, 1'b0);
		send_pixel(32'h00112234, 1'b1, 32'hffffffff, 1'b0);
		send_pixel(32'hff112233, 1'b0, 32'hffffffff, 1'b1);
		send_pixel(32'h11223344, 1'b1, 32'h00000000, 1'b1);
		apply_settings(MODE_KEY, 8'd255, 1'b0, 24'hffffff);
		send_pixel(32'h00ffffff, 1'b1, 32'h00000000, 1'b1);
		send_pixel(32'hfffffffe, 1'b1, 32'h00000000, 1'b1);
		apply_settings(MODE_KEY, 8'd0, 1'b1, 24'h000000);
		send_pixel(32'hff000000, 1'b1, 32'hffffffff, 1'b1);
		send_pixel(32'h00000001, 1'b1, 32'hffffffff, 1'b0);

		// Random phases, each under its own register settings
		for (int phase = 0; phase < PHASES; phase++) begin
			case ($urandom_range(3))
				0: begin
					alpha = 8'd0;
				end
				1: begin
					alpha = 8'd255;
				end
				default: begin
					alpha = 8'($urandom);
				end
			endcase
			case (phase)
				0: begin
					apply_settings(MODE_BLEND, 8'd255, 1'b0, 24'($urandom));
				end
				1: begin
					apply_settings(MODE_BLEND, alpha, 1'b1, 24'($urandom));
				end
				2: begin
					apply_settings(MODE_KEY, alpha, 1'($urandom), 24'h000000);
				end
				3: begin
					apply_settings(MODE_KEY, alpha, 1'($urandom), 24'hffffff);
				end
				default: begin
					apply_settings(blend_mode_t'($urandom_range(1)), alpha, 1'($urandom),
						24'($urandom));
				end
			endcase
			steady = (phase == 6);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				src    = random_pixel();
				dst    = random_pixel();
				src_ok = ($urandom_range(99) >= 12);
				dst_ok = ($urandom_range(99) >= 12);
				// steer a quarter of key-mode pixels onto the key
				if (board.mode == MODE_KEY && $urandom_range(3) == 0) begin
					src[23:0] = {board.color_key[7:0], board.color_key[15:8],
						board.color_key[23:16]};
				end
				send_pixel(src, src_ok, dst, dst_ok);
			end
		end
		steady = 1'b0;
		s_axis_tvalid <= 1'b0;

		// Wait for the last results, then let the pipeline settle
		while (board.pending() > 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (board.pending() > 0) begin
			board.report_mismatch("result never arrived", '0, board.due_pixels[0].pixel);
		end

		$display("Covered %0d pixels under %0d register settings, %0d results compared.",
			board.taken, settings_used + 1, board.checked);
		$display("%0d writes suppressed by validity or key; one %0d-cycle output hold-off.",
			board.suppressed, HOLD_CYCLES);
		if (board.errors == 0) begin
			$display("alpha_blend_color_key_compositor_top verification clean");
		end else begin
			$display("alpha_blend_color_key_compositor_top verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/abck_pkg.sv
rtl/alpha_blend_color_key_compositor_top.sv
rtl/abck_chk.sv
verif/tb_alpha_blend_color_key_compositor_top.sv
